### rtl/core/rclas_pkg.sv
// ----------------------------------------------------------------------------
// rclas_pkg
// Shared types and constants for the radio-link arming supervisor.
// ----------------------------------------------------------------------------
package rclas_pkg;

   localparam int unsigned CSR_W       = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned TICK_W      = 32;
   localparam int unsigned THR_W       = 16;
   localparam int unsigned SW_W        = 8;
   localparam int unsigned REQ_DATA_W  = 64;
   localparam int unsigned RSP_DATA_W  = 24;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_HIGH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_LOW      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL        = 2'd3;

   localparam logic [CSR_W-1:0] LINK_TIMEOUT_RST = 16'd500;
   localparam logic [CSR_W-1:0] THR_HIGH_RST     = 16'd900;
   localparam logic [CSR_W-1:0] THR_LOW_RST      = 16'd100;
   localparam logic [CSR_W-1:0] DWELL_RST        = 16'd1000;

   localparam logic [SW_W-1:0] SW_OFF = 8'd0;
   localparam logic [SW_W-1:0] SW_ON  = 8'd1;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_HOLD   = 2'd2,
      MODE_FAIL   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_FREE      = 3'd0,
      PH_HIGH      = 3'd1,
      PH_LEFT_HIGH = 3'd2,
      PH_LOW       = 3'd3,
      PH_UNLOCKED  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CSR_W-1:0] link_timeout;
      logic [CSR_W-1:0] thr_high;
      logic [CSR_W-1:0] thr_low;
      logic [CSR_W-1:0] dwell;
   } cfg_type;

   typedef struct packed {
      logic              rx_ok;
      logic [THR_W-1:0]  rx_throttle;
      logic [SW_W-1:0]   rx_hold_switch;
      logic              altitude_ok;
      logic [TICK_W-1:0] now_tick;
   } req_item_type;

   typedef struct packed {
      logic              link_up;
      mode_type          flight_mode;
      phase_type         arm_phase;
      logic              hold_entered;
      logic [THR_W-1:0]  hold_throttle;
   } rsp_item_type;

   typedef struct packed {
      logic              link_flag;
      logic [TICK_W-1:0] last_good_tick;
      phase_type         phase;
      logic [TICK_W-1:0] high_start;
      logic [TICK_W-1:0] low_start;
      mode_type          mode;
      logic [THR_W-1:0]  kept_throttle;
      logic [SW_W-1:0]   kept_switch;
      logic [SW_W-1:0]   prior_switch;
      logic [THR_W-1:0]  captured_throttle;
   } state_type;

endpackage

### rtl/core/rc_link_arming_supervisor.sv
// ----------------------------------------------------------------------------
// rc_link_arming_supervisor
// Radio-link watchdog, throttle arming sequence and flight-mode supervisor.
// ----------------------------------------------------------------------------
// Each req beat is one supervisor step and yields exactly one rsp beat. A beat
// is captured in an input register, the step logic then runs on it against the
// state registers, and the new state and the result are registered together
// once the result register is free. A new beat is taken every cycle while rsp
// is not stalled. The rate is set by the state loop through rclas_step;
// backpressure on rsp stalls the input register without losing beats. Write
// configuration only while no beat is in flight.
// ----------------------------------------------------------------------------
module rc_link_arming_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   // {now_tick[57:26], altitude_ok[25], rx_hold_switch[24:17],
   //  rx_throttle[16:1], rx_ok[0]}, zero padded
   input  logic [rclas_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // {pad[23], hold_throttle[22:7], hold_entered[6], arm_phase[5:3],
   //  flight_mode[2:1], link_up[0]}
   output logic [rclas_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wen,
   input  logic [rclas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rclas_pkg::CSR_W-1:0]       csr_wdata
);
   import rclas_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type in_data_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   state_type    st_ff;
   state_type    st_in;
   rsp_item_type step_rsp;
   rsp_item_type rsp_data_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         out_ready;
   logic         advance;
   logic         req_fire;

   assign req_item.rx_ok          = req_tdata[0];
   assign req_item.rx_throttle    = req_tdata[16:1];
   assign req_item.rx_hold_switch = req_tdata[24:17];
   assign req_item.altitude_ok    = req_tdata[25];
   assign req_item.now_tick       = req_tdata[57:26];

   rclas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rclas_step u_step (
      .cfg     (cfg),
      .st      (st_ff),
      .item    (in_data_ff),
      .st_next (st_in),
      .result  (step_rsp)
   );

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !out_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance)
            st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         in_data_ff <= req_item;
      if (advance)
         rsp_data_ff <= step_rsp;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.hold_throttle, rsp_data_ff.hold_entered,
                        rsp_data_ff.arm_phase, rsp_data_ff.flight_mode,
                        rsp_data_ff.link_up};

endmodule

### rtl/core/rclas_csr.sv
// ----------------------------------------------------------------------------
// rclas_csr
// Configuration registers: write-only, one register per index.
// ----------------------------------------------------------------------------
module rclas_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [rclas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rclas_pkg::CSR_W-1:0]     csr_wdata,
   output rclas_pkg::cfg_type              cfg
);
   import rclas_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_LINK_TIMEOUT: cfg_in.link_timeout = csr_wdata;
            CSR_THR_HIGH:     cfg_in.thr_high     = csr_wdata;
            CSR_THR_LOW:      cfg_in.thr_low      = csr_wdata;
            CSR_DWELL:        cfg_in.dwell        = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_timeout <= LINK_TIMEOUT_RST;
         cfg_ff.thr_high     <= THR_HIGH_RST;
         cfg_ff.thr_low      <= THR_LOW_RST;
         cfg_ff.dwell        <= DWELL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/rclas_step.sv
// ----------------------------------------------------------------------------
// rclas_step
// One supervisor step: packet latch, link watchdog, arming, flight mode.
// ----------------------------------------------------------------------------
module rclas_step (
   input  rclas_pkg::cfg_type      cfg,
   input  rclas_pkg::state_type    st,
   input  rclas_pkg::req_item_type item,
   output rclas_pkg::state_type    st_next,
   output rclas_pkg::rsp_item_type result
);
   import rclas_pkg::*;

   state_type         nx;
   logic              entered;
   logic              sw_rise;
   logic              unlock;
   logic [TICK_W-1:0] since_good;
   logic [TICK_W-1:0] since_high;
   logic [TICK_W-1:0] since_low;

   assign since_good = item.now_tick - st.last_good_tick;
   assign since_high = item.now_tick - st.high_start;
   assign since_low  = item.now_tick - st.low_start;

   always_comb begin
      nx      = st;
      entered = 1'b0;
      unlock  = 1'b0;

      if (item.rx_ok) begin
         nx.kept_throttle  = item.rx_throttle;
         nx.kept_switch    = item.rx_hold_switch;
         nx.last_good_tick = item.now_tick;
         nx.link_flag      = 1'b1;
      end else if (st.link_flag &&
                   since_good >= {{(TICK_W-CSR_W){1'b0}}, cfg.link_timeout}) begin
         nx.link_flag = 1'b0;
      end

      sw_rise = (nx.kept_switch == SW_ON) && (st.prior_switch == SW_OFF);

      case (st.mode)
         MODE_IDLE: begin
            if (!nx.link_flag) begin
               nx.phase = PH_FREE;
            end else begin
               case (st.phase)
                  PH_FREE: begin
                     if (nx.kept_throttle > cfg.thr_high) begin
                        nx.phase      = PH_HIGH;
                        nx.high_start = item.now_tick;
                     end
                  end
                  PH_HIGH: begin
                     if (nx.kept_throttle <= cfg.thr_high)
                        nx.phase = PH_FREE;
                     else if (since_high >= {{(TICK_W-CSR_W){1'b0}}, cfg.dwell})
                        nx.phase = PH_LEFT_HIGH;
                  end
                  PH_LEFT_HIGH: begin
                     if (nx.kept_throttle <= cfg.thr_low) begin
                        nx.phase     = PH_LOW;
                        nx.low_start = item.now_tick;
                     end
                  end
                  PH_LOW: begin
                     if (nx.kept_throttle > cfg.thr_low)
                        nx.phase = PH_FREE;
                     else if (since_low >= {{(TICK_W-CSR_W){1'b0}}, cfg.dwell})
                        nx.phase = PH_UNLOCKED;
                  end
                  PH_UNLOCKED: unlock = 1'b1;
                  default:     nx.phase = PH_FREE;
               endcase
            end
            if (unlock) begin
               nx.mode  = MODE_NORMAL;
               nx.phase = PH_FREE;
            end
         end
         MODE_NORMAL: begin
            if (sw_rise && item.altitude_ok) begin
               entered              = 1'b1;
               nx.captured_throttle = nx.kept_throttle;
               nx.mode              = MODE_HOLD;
            end
            // link loss wins over a hold entry in the same step
            if (!nx.link_flag)
               nx.mode = MODE_FAIL;
         end
         MODE_HOLD: begin
            if (sw_rise)
               nx.mode = MODE_NORMAL;
            if (!nx.link_flag)
               nx.mode = MODE_FAIL;
         end
         default: nx.mode = MODE_IDLE;
      endcase

      nx.prior_switch = nx.kept_switch;
   end

   assign st_next              = nx;
   assign result.link_up       = nx.link_flag;
   assign result.flight_mode   = nx.mode;
   assign result.arm_phase     = nx.phase;
   assign result.hold_entered  = entered;
   assign result.hold_throttle = nx.captured_throttle;

endmodule

### rtl/core/rclas_checker.sv
// ----------------------------------------------------------------------------
// rclas_checker
// Port-level checks on the supervisor's result stream.
// ----------------------------------------------------------------------------
module rclas_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [rclas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import rclas_pkg::*;

   logic       link_up;
   logic [1:0] mode;
   logic [2:0] phase;
   logic       entered;

   assign link_up = rsp_tdata[0];
   assign mode    = rsp_tdata[2:1];
   assign phase   = rsp_tdata[5:3];
   assign entered = rsp_tdata[6];

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // a hold entry only shows with the link up and the mode in hold
   a_entry_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && entered |-> link_up && mode == MODE_HOLD)
      else $error("hold entry without hold mode");

   // fail is only reached through link loss
   a_fail_link: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode == MODE_FAIL |-> !link_up)
      else $error("fail mode with link up");

   // arming sequence is parked at free outside idle
   a_phase_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode == MODE_NORMAL || mode == MODE_HOLD || mode == MODE_FAIL)
      |-> phase == PH_FREE)
      else $error("arming phase active outside idle");

   // no arming progress without a link
   a_phase_link: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !link_up |-> phase == PH_FREE)
      else $error("arming phase active with link down");

endmodule

bind rc_link_arming_supervisor rclas_checker u_rclas_checker (.*);

### sim/rc_link_arming_supervisor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_link_arming_supervisor_tb
// Self-checking bench for the radio-link arming supervisor.
// ----------------------------------------------------------------------------
// A table of directed steps walks the block through a full arming sequence,
// hold entry and exit, link loss and tick wraparound at the reset limits.
// After that, each of several limit settings (the extremes among them) gets a
// run of random steps. Most of these steps are steered by the bench's own
// copy of the supervisor state so that they reach deep into the arming and
// flight-mode logic; the rest are noise. Every status beat is checked field
// by field against that copy. The sender runs in bursts, the receiver stalls
// on its own pattern, and twice it holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module rc_link_arming_supervisor_tb;
   import rclas_pkg::*;

   localparam int unsigned ITEMS_PER_SETTING = 305;
   localparam int unsigned WATCHDOG_LIMIT    = 1000;
   localparam int unsigned LONG_HOLD_OFF     = 150;

   typedef struct packed {
      req_item_type stim;
      logic         typed;
      rsp_item_type want;
   } probe_row_type;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_SPARSE,
      DRAIN_PERIODIC,
      DRAIN_HEAVY
   } drain_type;

   localparam rsp_item_type UNTYPED = '0;

   // directed steps at the reset limits (timeout 500, high 900, low 100, dwell 1000)
   localparam probe_row_type PROBE_TABLE [22] = '{
      '{'{1'b0, 16'h0000, 8'h00, 1'b0, 32'd0}, 1'b1,
        '{1'b0, MODE_IDLE, PH_FREE, 1'b0, 16'h0000}},
      '{'{1'b1, 16'hFFFF, 8'h00, 1'b1, 32'd10}, 1'b1,
        '{1'b1, MODE_IDLE, PH_HIGH, 1'b0, 16'h0000}},
      '{'{1'b1, 16'hFFFF, 8'h00, 1'b0, 32'd1009}, 1'b0, UNTYPED},
      '{'{1'b1, 16'hFFFF, 8'h00, 1'b0, 32'd1010}, 1'b0, UNTYPED},
      '{'{1'b1, 16'h0000, 8'h00, 1'b0, 32'd1020}, 1'b0, UNTYPED},
      '{'{1'b1, 16'd100, 8'h00, 1'b0, 32'd2020}, 1'b1,
        '{1'b1, MODE_IDLE, PH_UNLOCKED, 1'b0, 16'h0000}},
      '{'{1'b1, 16'h0000, 8'h00, 1'b0, 32'd2021}, 1'b1,
        '{1'b1, MODE_NORMAL, PH_FREE, 1'b0, 16'h0000}},
      // switch edge without the altitude sensor
      '{'{1'b1, 16'h1234, 8'h01, 1'b0, 32'd2022}, 1'b0, UNTYPED},
      '{'{1'b1, 16'h1234, 8'h00, 1'b1, 32'd2023}, 1'b0, UNTYPED},
      '{'{1'b1, 16'hABCD, 8'h01, 1'b1, 32'd2024}, 1'b1,
        '{1'b1, MODE_HOLD, PH_FREE, 1'b1, 16'hABCD}},
      '{'{1'b1, 16'h0000, 8'h00, 1'b1, 32'd2025}, 1'b0, UNTYPED},
      '{'{1'b1, 16'h0000, 8'h01, 1'b0, 32'd2026}, 1'b1,
        '{1'b1, MODE_NORMAL, PH_FREE, 1'b0, 16'hABCD}},
      // 0xFF -> 0x01 is not an edge
      '{'{1'b1, 16'h5555, 8'hFF, 1'b1, 32'd2027}, 1'b0, UNTYPED},
      '{'{1'b1, 16'h5555, 8'h01, 1'b1, 32'd2028}, 1'b0, UNTYPED},
      '{'{1'b1, 16'h0000, 8'h00, 1'b1, 32'd2029}, 1'b0, UNTYPED},
      // switch byte without a valid packet is not latched
      '{'{1'b0, 16'hFFFF, 8'h01, 1'b1, 32'd2030}, 1'b0, UNTYPED},
      '{'{1'b0, 16'h0000, 8'h00, 1'b0, 32'd2529}, 1'b1,
        '{1'b0, MODE_FAIL, PH_FREE, 1'b0, 16'hABCD}},
      '{'{1'b0, 16'h0000, 8'h00, 1'b0, 32'd2530}, 1'b1,
        '{1'b0, MODE_IDLE, PH_FREE, 1'b0, 16'hABCD}},
      // dwell measured across the tick wrap
      '{'{1'b1, 16'hFFFF, 8'h00, 1'b0, 32'hFFFF_FFF0}, 1'b0, UNTYPED},
      '{'{1'b1, 16'hFFFF, 8'h00, 1'b0, 32'h0000_03D8}, 1'b1,
        '{1'b1, MODE_IDLE, PH_LEFT_HIGH, 1'b0, 16'hABCD}},
      // link drops mid-sequence
      '{'{1'b0, 16'h0000, 8'h00, 1'b0, 32'h0000_05CC}, 1'b1,
        '{1'b0, MODE_IDLE, PH_FREE, 1'b0, 16'hABCD}},
      '{'{1'b1, 16'h8000, 8'hAA, 1'b1, 32'h8000_0000}, 1'b0, UNTYPED}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   // bench copy of the supervisor: limits and state
   cfg_type      cfg = '{LINK_TIMEOUT_RST, THR_HIGH_RST, THR_LOW_RST, DWELL_RST};
   state_type    sup = '0;
   rsp_item_type status_q [$];

   cfg_type cfg_plan [6] = '{
      '{16'd40,    16'd900,   16'd100,   16'd20},
      '{16'd0,     16'd0,     16'd0,     16'd0},
      '{16'hFFFF,  16'hFFFE,  16'hFFFF,  16'hFFFF},
      '{16'd7,     16'hFFFF,  16'd0,     16'd3},
      '{16'd300,   16'd2000,  16'd500,   16'd64},
      '{16'd500,   16'd900,   16'd100,   16'd10}
   };

   int unsigned req_beats = 0;
   int unsigned rsp_beats = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left = 0;
   bit          steady = 1'b0;

   drain_type   drain_kind = DRAIN_FREE;
   int unsigned drain_left = 0;
   int unsigned hold_off_left = 0;
   int unsigned next_hold_off_at = 400;
   logic [1:0]  drain_phase = '0;

   rc_link_arming_supervisor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one supervisor step on the bench copy; returns the status it reports
   function automatic rsp_item_type supervise_step(input req_item_type it);
      rsp_item_type r;
      logic         sw_rise;
      r = '0;
      if (it.rx_ok) begin
         sup.kept_throttle  = it.rx_throttle;
         sup.kept_switch    = it.rx_hold_switch;
         sup.last_good_tick = it.now_tick;
         sup.link_flag      = 1'b1;
      end else if (sup.link_flag &&
                   it.now_tick - sup.last_good_tick >= {16'd0, cfg.link_timeout}) begin
         sup.link_flag = 1'b0;
      end
      sw_rise = (sup.kept_switch == SW_ON) && (sup.prior_switch == SW_OFF);
      case (sup.mode)
         MODE_IDLE: begin
            if (!sup.link_flag) begin
               sup.phase = PH_FREE;
            end else begin
               case (sup.phase)
                  PH_FREE: begin
                     if (sup.kept_throttle > cfg.thr_high) begin
                        sup.phase      = PH_HIGH;
                        sup.high_start = it.now_tick;
                     end
                  end
                  PH_HIGH: begin
                     if (sup.kept_throttle <= cfg.thr_high)
                        sup.phase = PH_FREE;
                     else if (it.now_tick - sup.high_start >= {16'd0, cfg.dwell})
                        sup.phase = PH_LEFT_HIGH;
                  end
                  PH_LEFT_HIGH: begin
                     if (sup.kept_throttle <= cfg.thr_low) begin
                        sup.phase     = PH_LOW;
                        sup.low_start = it.now_tick;
                     end
                  end
                  PH_LOW: begin
                     if (sup.kept_throttle > cfg.thr_low)
                        sup.phase = PH_FREE;
                     else if (it.now_tick - sup.low_start >= {16'd0, cfg.dwell})
                        sup.phase = PH_UNLOCKED;
                  end
                  // unlocked was already reported last step: arm now
                  PH_UNLOCKED: begin
                     sup.mode  = MODE_NORMAL;
                     sup.phase = PH_FREE;
                  end
                  default: sup.phase = PH_FREE;
               endcase
            end
         end
         MODE_NORMAL: begin
            if (sw_rise && it.altitude_ok) begin
               r.hold_entered        = 1'b1;
               sup.captured_throttle = sup.kept_throttle;
               sup.mode              = MODE_HOLD;
            end
            if (!sup.link_flag)
               sup.mode = MODE_FAIL;
         end
         MODE_HOLD: begin
            if (sw_rise)
               sup.mode = MODE_NORMAL;
            if (!sup.link_flag)
               sup.mode = MODE_FAIL;
         end
         default: sup.mode = MODE_IDLE;
      endcase
      sup.prior_switch = sup.kept_switch;
      r.link_up       = sup.link_flag;
      r.flight_mode   = sup.mode;
      r.arm_phase     = sup.phase;
      r.hold_throttle = sup.captured_throttle;
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic offer_step(input req_item_type it, input logic typed,
                             input rsp_item_type typed_status);
      rsp_item_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, it.now_tick, it.altitude_ok, it.rx_hold_switch,
                     it.rx_throttle, it.rx_ok};
      do @(posedge clock); while (!req_tready);
      predicted = supervise_step(it);
      status_q.push_back(typed ? typed_status : predicted);
      req_beats++;
      @(negedge clock);
   endtask

   // keeps csr_wen high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LINK_TIMEOUT: cfg.link_timeout = val;
         CSR_THR_HIGH:     cfg.thr_high     = val;
         CSR_THR_LOW:      cfg.thr_low      = val;
         CSR_DWELL:        cfg.dwell        = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   initial begin
      req_item_type step_in;
      int unsigned  roll;
      logic [31:0]  pace;
      logic [31:0]  tick_now;
      cfg_plan[5].link_timeout = 16'($urandom_range(1, 2000));
      cfg_plan[5].thr_high     = 16'($urandom_range(0, 16'hFFFF));
      cfg_plan[5].thr_low      = 16'($urandom_range(0, 16'hFFFF));
      cfg_plan[5].dwell        = 16'($urandom_range(0, 200));
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < $size(PROBE_TABLE); i++)
         offer_step(PROBE_TABLE[i].stim, PROBE_TABLE[i].typed, PROBE_TABLE[i].want);

      for (int s = 0; s < $size(cfg_plan); s++) begin
         // limits change only with nothing in flight
         req_tvalid <= 1'b0;
         while (status_q.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
         write_csr(CSR_LINK_TIMEOUT, cfg_plan[s].link_timeout);
         write_csr(CSR_THR_HIGH, cfg_plan[s].thr_high);
         write_csr(CSR_THR_LOW, cfg_plan[s].thr_low);
         write_csr(CSR_DWELL, cfg_plan[s].dwell);
         csr_wen <= 1'b0;
         steady   = ($urandom_range(0, 2) == 0);
         tick_now = s[0] ? 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF) : $urandom;
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            roll = $urandom_range(0, 99);
            pace = $urandom_range(0, cfg.dwell / 4 + 2);
            step_in.rx_ok          = 1'b1;
            step_in.rx_throttle    = 16'($urandom_range(0, 16'hFFFF));
            step_in.rx_hold_switch = 8'($urandom_range(0, 255));
            step_in.altitude_ok    = ($urandom_range(0, 3) != 0);
            if (roll < 12) begin
               // noise, sometimes with a wild tick jump
               step_in.rx_ok       = 1'($urandom_range(0, 1));
               step_in.altitude_ok = 1'($urandom_range(0, 1));
               if (roll < 4)
                  pace = $urandom;
            end else if (roll < 20) begin
               step_in.rx_ok = 1'b0;
               pace = cfg.link_timeout + $urandom_range(0, 3);
            end else if (sup.mode == MODE_IDLE) begin
               // push the arming sequence forward most of the time
               if (roll >= 28 && (sup.phase == PH_FREE || sup.phase == PH_HIGH) &&
                   cfg.thr_high != 16'hFFFF)
                  step_in.rx_throttle = 16'($urandom_range(cfg.thr_high + 1, 16'hFFFF));
               else if (roll >= 28 && (sup.phase == PH_LEFT_HIGH || sup.phase == PH_LOW))
                  step_in.rx_throttle = 16'($urandom_range(0, cfg.thr_low));
            end else if (sup.mode != MODE_FAIL) begin
               if ($urandom_range(0, 9) < 8)
                  step_in.rx_hold_switch = (sup.kept_switch == SW_OFF) ? SW_ON : SW_OFF;
               if (roll >= 92) begin
                  step_in.rx_ok = 1'b0;
                  pace = $urandom_range(0, 3);
               end
            end
            step_in.now_tick = tick_now + pace;
            tick_now = step_in.now_tick;
            offer_step(step_in, 1'b0, UNTYPED);
         end
      end

      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && status_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // receiver: changing stall patterns plus two long hold-offs that fill the block
   always @(negedge clock) begin
      drain_phase <= drain_phase + 2'd1;
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready    <= 1'b0;
      end else if (req_beats >= next_hold_off_at) begin
         hold_off_left    <= LONG_HOLD_OFF;
         next_hold_off_at <= next_hold_off_at + 900;
         rsp_tready       <= 1'b0;
      end else begin
         if (drain_left == 0) begin
            drain_kind <= drain_type'($urandom_range(0, 3));
            drain_left <= $urandom_range(16, 200);
         end else begin
            drain_left <= drain_left - 1;
         end
         case (drain_kind)
            DRAIN_FREE:     rsp_tready <= 1'b1;
            DRAIN_SPARSE:   rsp_tready <= ($urandom_range(0, 9) < 7);
            DRAIN_PERIODIC: rsp_tready <= (drain_phase != 2'd0);
            default:        rsp_tready <= ($urandom_range(0, 9) < 2);
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[2:1], rsp_tdata[5:3], rsp_tdata[6], rsp_tdata[22:7]};
         if (status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("status beat %0d arrived with nothing pending: %h",
                        rsp_beats, rsp_tdata);
         end else begin
            want = status_q.pop_front();
            if (got.link_up !== want.link_up || got.flight_mode !== want.flight_mode ||
                got.arm_phase !== want.arm_phase || got.hold_entered !== want.hold_entered ||
                got.hold_throttle !== want.hold_throttle) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("status beat %0d mismatch: expected link=%0b mode=%0d phase=%0d entered=%0b thr=%h",
                           rsp_beats, want.link_up, want.flight_mode, want.arm_phase,
                           want.hold_entered, want.hold_throttle);
                  $display("   got link=%0b mode=%0d phase=%0d entered=%0b thr=%h",
                           got.link_up, got.flight_mode, got.arm_phase,
                           got.hold_entered, got.hold_throttle);
               end
            end
         end
         rsp_beats++;
      end
   end

   // watchdog on cycles with no beat taken on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
